### rtl/core/tmcs_pkg.sv
// Package with shared types, constants and helper functions for the MCS selector.
package tmcs_pkg;

	localparam logic OP_FEEDBACK = 1'b0;
	localparam logic OP_REQUEST  = 1'b1;

	localparam logic [4:0] MCS_MIN = 5'd3;
	localparam logic [4:0] MCS_MAX = 5'd25;
	localparam logic signed [2:0] OFS_MIN = -3'sd3;
	localparam logic signed [2:0] OFS_MAX = 3'sd2;
	localparam logic [7:0] NACK_LIMIT = 8'd100;
	localparam logic [16:0] ALPHA_Q16 = 17'd1311;
	localparam logic [16:0] ALPHA_KEEP = 17'd64225;

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		logic [4:0]        tree_mcs;
		logic signed [2:0] offset_now;
		logic              fallback;
	} req_t;

	// Floors a threshold given in units of 1e-8 to the measurement scale.
	function automatic longint thr_floor(input longint t_e8, input int frac);
		longint num;
		num = t_e8 * (longint'(1) << frac);
		if (num >= 0)
			return num / 100000000;
		else
			return -((-num + 99999999) / 100000000);
	endfunction

	// Snaps a clamped sum in 3..25 to the nearest allowed MCS, ties low.
	function automatic logic [4:0] snap_mcs(input logic [4:0] raw);
		logic [4:0] r;
		case (raw)
			5'd3:  r = 5'd3;
			5'd4, 5'd5, 5'd6: r = 5'd4;
			5'd7, 5'd8, 5'd9, 5'd10: r = 5'd9;
			5'd11, 5'd12: r = 5'd11;
			5'd13, 5'd14, 5'd15: r = 5'd14;
			5'd16, 5'd17, 5'd18: r = 5'd17;
			5'd19, 5'd20, 5'd21, 5'd22: r = 5'd20;
			5'd23, 5'd24: r = 5'd24;
			5'd25: r = 5'd25;
			default: r = 5'd3;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/tree_mcs_select_with_olla.sv
// Top level of the outer-loop link adaptation MCS selector.
// Input stream s_axis: one transaction is either HARQ feedback (op 0) or an
// MCS request (op 1). Feedback updates the error average and the NACK run
// and gives no result. A request gives one result transaction on m_axis.
// The front part classifies and evaluates the decision tree in the cycle
// the transaction is accepted; the result sits in a two-entry queue and is
// offered on m_axis after any older result. The block takes one transaction
// per cycle while s_axis_tready is high; the tree and state update in the
// front part finish in the accept cycle. When the receiver stalls, the
// queue fills and s_axis_tready drops only while the queue is full and
// m_axis_tready is low. Reset clears the state: average, NACK run and
// offset to zero, target to 6554, queue empty. cfg_we writes the BLER
// target; write it only while idle: the block does not enforce this.
module tree_mcs_select_with_olla #(
	parameter int AVG_BITS       = 16,
	parameter int MEAS_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op, ack, sinr_q8, speed_q8, channel_class, band, antennas, pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mcs, tree_mcs, offset_now, pad
	output logic [15:0] m_axis_tdata,
	// fallback
	output logic        m_axis_tuser
);
	import tmcs_pkg::*;

	logic in_fire;
	logic req_push;
	req_t req;
	req_t out_req;
	logic [4:0] mcs;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	tmcs_front #(.AVG_BITS(AVG_BITS), .MEAS_FRAC_BITS(MEAS_FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_fire(in_fire), .op(s_axis_tdata[0]), .ack(s_axis_tdata[1]),
		.sinr(s_axis_tdata[17:2]), .speed(s_axis_tdata[33:18]),
		.ch(s_axis_tdata[35:34]), .bd(s_axis_tdata[36]), .an(s_axis_tdata[40:37]),
		.req_push(req_push), .req(req)
	);

	tmcs_back u_back (
		.clk(clk), .arst_n(arst_n), .req_push(req_push), .req(req),
		.can_take(s_axis_tready), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .mcs(mcs), .out_req(out_req)
	);

	assign m_axis_tdata = {3'd0, out_req.offset_now, out_req.tree_mcs, mcs};
	assign m_axis_tuser = out_req.fallback;

endmodule

### rtl/core/tmcs_tree.sv
// Fixed decision tree that maps measurements to a base MCS.
module tmcs_tree #(
	parameter int MEAS_FRAC_BITS = 8
) (
	input  logic signed [15:0] sinr,
	input  logic [15:0]        speed,
	input  logic [1:0]         ch,
	input  logic               bd,
	input  logic [3:0]         an,
	output logic [4:0]         tree_mcs
);
	import tmcs_pkg::*;

	logic signed [17:0] s;
	logic signed [17:0] v;
	logic c0, c2, b0, a1;

	function automatic logic le(input logic signed [17:0] x, input longint t);
		longint q;
		q = thr_floor(t, MEAS_FRAC_BITS);
		return longint'(x) <= q;
	endfunction

	assign s  = 18'(sinr);
	assign v  = {2'b00, speed};
	assign c0 = (ch == 2'd0);
	assign c2 = (ch <= 2'd2);
	assign b0 = ~bd;
	assign a1 = (an <= 4'd1);

	// Comparator tree; every node is a constant compare.
	always_comb begin
		if (le(s, 64'd430839133)) begin
			if (le(s, -96642464)) begin
				if (le(s, -248702228)) tree_mcs = 5'd3;
				else if (c0 && le(v, 64'd7019161415)) begin
					if (a1) tree_mcs = 5'd3;
					else tree_mcs = le(v, 64'd1802309258) ? 5'd4 : 5'd3;
				end else tree_mcs = 5'd3;
			end else if (c0) begin
				if (le(s, 64'd126274550)) begin
					if (b0) tree_mcs = le(v, 64'd6853525734) ? 5'd4 : 5'd3;
					else tree_mcs = 5'd3;
				end else tree_mcs = 5'd4;
			end else if (le(v, 64'd55807936)) begin
				if (le(s, 64'd156168413)) tree_mcs = le(s, 64'd41184593) ? 5'd4 : 5'd3;
				else tree_mcs = 5'd4;
			end else tree_mcs = 5'd3;
		end else if (le(s, 64'd1256060553)) begin
			if (le(s, 64'd617890668)) begin
				if (le(v, 64'd399698102)) begin
					if (c0) tree_mcs = le(v, 64'd41157654) ? 5'd9 : 5'd4;
					else tree_mcs = 5'd4;
				end else if (le(s, 64'd454392958)) tree_mcs = c2 ? 5'd9 : 5'd4;
				else if (le(v, 64'd12433786774)) tree_mcs = 5'd4;
				else tree_mcs = c2 ? 5'd4 : 5'd3;
			end else if (le(s, 64'd882764578)) begin
				if (c0) begin
					if (le(s, 64'd705531454)) begin
						if (le(v, 64'd100115356)) tree_mcs = a1 ? 5'd11 : 5'd9;
						else if (le(s, 64'd662034631)) tree_mcs = 5'd9;
						else tree_mcs = le(s, 64'd676861310) ? 5'd11 : 5'd9;
					end else if (le(v, 64'd1273514843)) begin
						if (a1) tree_mcs = 5'd11;
						else tree_mcs = le(v, 64'd453145599) ? 5'd14 : 5'd11;
					end else tree_mcs = le(v, 64'd11855266190) ? 5'd11 : 5'd9;
				end else if (a1) begin
					if (le(v, 64'd150999677))
						tree_mcs = le(s, 64'd724577546) ? 5'd9 : 5'd11;
					else tree_mcs = 5'd9;
				end else if (c2) begin
					if (le(s, 64'd753271031)) tree_mcs = b0 ? 5'd9 : 5'd4;
					else tree_mcs = le(v, 64'd7928376770) ? 5'd9 : 5'd4;
				end else tree_mcs = le(v, 64'd12831045914) ? 5'd4 : 5'd3;
			end else if (le(s, 64'd1087900114)) begin
				if (a1) tree_mcs = 5'd11;
				else if (c0) begin
					if (b0) tree_mcs = le(s, 64'd906382465) ? 5'd11 : 5'd14;
					else tree_mcs = 5'd11;
				end else tree_mcs = le(v, 64'd3681468201) ? 5'd11 : 5'd9;
			end else if (le(v, 64'd10910931778)) begin
				if (c0) tree_mcs = le(v, 64'd472279215) ? 5'd17 : 5'd14;
				else if (a1) tree_mcs = 5'd14;
				else tree_mcs = le(v, 64'd3220698929) ? 5'd11 : 5'd9;
			end else if (le(s, 64'd1145182133))
				tree_mcs = le(s, 64'd1113978100) ? 5'd11 : 5'd9;
			else tree_mcs = 5'd11;
		end else if (le(s, 64'd1716288471)) begin
			if (c0) begin
				if (le(v, 64'd11294168854)) begin
					if (le(s, 64'd1670649338))
						tree_mcs = le(v, 64'd10961881256) ? 5'd17 : 5'd11;
					else tree_mcs = le(s, 64'd1677868176) ? 5'd20 : 5'd17;
				end else if (b0) tree_mcs = 5'd17;
				else tree_mcs = le(s, 64'd1533669233) ? 5'd11 : 5'd14;
			end else if (le(v, 64'd3318185043)) begin
				if (a1) tree_mcs = le(s, 64'd1421487474) ? 5'd14 : 5'd17;
				else if (le(s, 64'd1494774055))
					tree_mcs = le(v, 64'd850468922) ? 5'd14 : 5'd11;
				else tree_mcs = 5'd14;
			end else if (a1) begin
				if (le(s, 64'd1459946728))
					tree_mcs = le(v, 64'd11704510117) ? 5'd14 : 5'd11;
				else tree_mcs = 5'd17;
			end else if (le(s, 64'd1408268023))
				tree_mcs = le(s, 64'd1307105064) ? 5'd11 : 5'd9;
			else tree_mcs = 5'd11;
		end else if (le(v, 64'd5835043716)) begin
			if (le(s, 64'd2322297764)) begin
				if (le(s, 64'd1882577515)) begin
					if (c0) tree_mcs = 5'd20;
					else if (b0) tree_mcs = 5'd17;
					else if (le(v, 64'd1129361582)) tree_mcs = 5'd17;
					else tree_mcs = a1 ? 5'd17 : 5'd14;
				end else if (le(v, 64'd828355694)) begin
					if (le(s, 64'd2062684345)) tree_mcs = c0 ? 5'd24 : 5'd20;
					else if (c0) tree_mcs = 5'd25;
					else if (a1) tree_mcs = b0 ? 5'd24 : 5'd25;
					else tree_mcs = 5'd20;
				end else if (c0) begin
					if (le(v, 64'd3418718910))
						tree_mcs = le(v, 64'd1419350100) ? 5'd24 : 5'd20;
					else tree_mcs = 5'd24;
				end else if (a1) tree_mcs = 5'd20;
				else if (c2) tree_mcs = b0 ? 5'd20 : 5'd14;
				else tree_mcs = 5'd14;
			end else if (le(v, 64'd1215252781)) begin
				if (c0) tree_mcs = 5'd25;
				else if (c2) begin
					if (a1) tree_mcs = 5'd25;
					else tree_mcs = le(s, 64'd2811477184) ? 5'd20 : 5'd24;
				end else if (b0) tree_mcs = 5'd24;
				else tree_mcs = le(v, 64'd55706936) ? 5'd25 : 5'd24;
			end else if (b0) begin
				if (le(s, 64'd2537801456)) begin
					if (le(s, 64'd2449721813)) begin
						if (le(s, 64'd2374157238)) tree_mcs = 5'd24;
						else tree_mcs = le(s, 64'd2433358669) ? 5'd20 : 5'd24;
					end else tree_mcs = 5'd20;
				end else tree_mcs = 5'd24;
			end else if (le(v, 64'd3600370216)) begin
				if (c0) tree_mcs = le(s, 64'd2615872860) ? 5'd24 : 5'd20;
				else tree_mcs = le(v, 64'd2845121098) ? 5'd20 : 5'd17;
			end else tree_mcs = c2 ? 5'd17 : 5'd14;
		end else if (c0) begin
			if (le(v, 64'd12184026337)) begin
				if (le(s, 64'd2434941578)) tree_mcs = 5'd20;
				else tree_mcs = a1 ? 5'd24 : 5'd20;
			end else if (b0) tree_mcs = le(s, 64'd2112915993) ? 5'd17 : 5'd20;
			else tree_mcs = le(v, 64'd13305709076) ? 5'd17 : 5'd14;
		end else if (b0) begin
			if (a1) tree_mcs = le(v, 64'd12573830414) ? 5'd17 : 5'd14;
			else tree_mcs = c2 ? 5'd14 : 5'd11;
		end else tree_mcs = 5'd11;
	end

endmodule

### rtl/core/tmcs_front.sv
// Front part: accepts items, updates link state and classifies requests.
module tmcs_front #(
	parameter int AVG_BITS       = 16,
	parameter int MEAS_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_fire,
	input  logic               op,
	input  logic               ack,
	input  logic signed [15:0] sinr,
	input  logic [15:0]        speed,
	input  logic [1:0]         ch,
	input  logic               bd,
	input  logic [3:0]         an,
	output logic               req_push,
	output tmcs_pkg::req_t     req
);
	import tmcs_pkg::*;

	localparam int ACC_W = AVG_BITS + 17;

	logic [15:0]         target_rate_q;
	logic [AVG_BITS-1:0] error_average_q;
	logic [7:0]          nack_run_q;
	logic signed [2:0]   rate_offset_q;
	logic [ACC_W-1:0]    acc;
	logic [AVG_BITS+16:0] avg_al;
	logic [AVG_BITS+16:0] tgt_al;
	logic                fb;
	logic signed [2:0]   ofs_next;
	logic [4:0]          tree_mcs;

	tmcs_tree #(.MEAS_FRAC_BITS(MEAS_FRAC_BITS)) u_tree (
		.sinr(sinr), .speed(speed), .ch(ch), .bd(bd), .an(an), .tree_mcs(tree_mcs)
	);

	// Average update: one 17 by AVG_BITS multiply and an add.
	always_comb begin
		acc = ACC_W'(error_average_q) * ACC_W'(ALPHA_KEEP);
		if (!ack)
			acc = acc + (ACC_W'(ALPHA_Q16) << AVG_BITS);
	end

	// Offset step against the target and half the target on a common scale.
	always_comb begin
		avg_al   = {1'b0, error_average_q, 16'd0};
		tgt_al   = {1'b0, target_rate_q, AVG_BITS'(0)};
		fb       = (nack_run_q > NACK_LIMIT);
		ofs_next = rate_offset_q;
		if (avg_al > tgt_al) begin
			if (rate_offset_q > OFS_MIN) ofs_next = rate_offset_q - 3'sd1;
		end else if ({avg_al, 1'b0} < {1'b0, tgt_al}) begin
			if (rate_offset_q < OFS_MAX) ofs_next = rate_offset_q + 3'sd1;
		end
	end

	// Link state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_rate_q   <= 16'd6554;
			error_average_q <= '0;
			nack_run_q      <= '0;
			rate_offset_q   <= '0;
		end else begin
			if (cfg_we) target_rate_q <= cfg_wdata;
			if (in_fire && op == OP_FEEDBACK) begin
				error_average_q <= acc[AVG_BITS+15 -: AVG_BITS];
				if (ack) nack_run_q <= '0;
				else if (nack_run_q != 8'hFF) nack_run_q <= nack_run_q + 8'd1;
			end
			if (in_fire && op == OP_REQUEST && !fb)
				rate_offset_q <= ofs_next;
		end
	end

	// Classified request toward the queue.
	always_comb begin
		req_push       = in_fire && (op == OP_REQUEST);
		req.fallback   = fb;
		req.tree_mcs   = fb ? MCS_MIN : tree_mcs;
		req.offset_now = fb ? rate_offset_q : ofs_next;
	end

endmodule

### rtl/core/tmcs_back.sv
// Back part: two-entry queue and the offset, clamp and snap stage.
module tmcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_push,
	input  tmcs_pkg::req_t req,
	output logic           can_take,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [4:0]     mcs,
	output tmcs_pkg::req_t out_req
);
	import tmcs_pkg::*;

	req_t        slot_q [2];
	logic        rd_ptr_q, wr_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;
	logic signed [6:0] sum;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign can_take  = (cnt_q != 2'd2) || out_ready;
	assign out_req   = slot_q[rd_ptr_q];

	// Queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (req_push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, req_push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (req_push) slot_q[wr_ptr_q] <= req;
	end

	// Offset add, clamp to the legal range and snap.
	always_comb begin
		sum = $signed({2'b00, out_req.tree_mcs}) + 7'(out_req.offset_now);
		if (out_req.fallback) mcs = MCS_MIN;
		else if (sum < $signed({2'b00, MCS_MIN})) mcs = MCS_MIN;
		else if (sum > $signed({2'b00, MCS_MAX})) mcs = MCS_MAX;
		else mcs = snap_mcs(sum[4:0]);
	end

endmodule

### rtl/core/tmcs_checker.sv
// Port-level checker for the MCS selector and its bind statement.
module tmcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	// A fallback result always carries MCS 3 in both MCS fields.
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[9:0] == 10'd99)
		else $error("fallback result not MCS 3");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// An accepted request shows a result in the next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> m_axis_tvalid)
		else $error("request gave no result");

	// The offset field stays in -3..2.
	a_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[12:10] != 3'b011 && m_axis_tdata[12:10] != 3'b100)
		else $error("offset out of range");
endmodule

bind tree_mcs_select_with_olla tmcs_checker u_checker (.*);

### dv/tree_mcs_select_with_olla_test.sv
// Self-checking testbench for the outer-loop link adaptation MCS selector.
module tree_mcs_select_with_olla_test;
	import tmcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One input transaction, split into its fields.
	typedef struct {
		logic              op;
		logic              ack;
		logic signed [15:0] sinr;
		logic [15:0]       speed;
		logic [1:0]        cls;
		logic              band;
		logic [3:0]        ant;
	} link_item_t;

	// One result transaction.
	typedef struct {
		logic [4:0]        mcs;
		logic [4:0]        tree;
		logic signed [2:0] ofs;
		logic              fb;
	} mcs_result_t;

	// Directed stimulus row, with an optional typed-in result.
	typedef struct {
		link_item_t  item;
		bit          typed;
		mcs_result_t res;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	tree_mcs_select_with_olla dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Shadow copy of the link state and the target.
	logic [15:0]      bler_avg;
	logic [7:0]       nack_count;
	int               link_offset;
	logic [15:0]      bler_goal;

	mcs_result_t pending_mcs[$];
	int  fail_count;
	int  n_requests, n_feedback, n_fallback, n_results;
	bit  calm;
	bit  hold_request;
	int  stall_left;
	int  quiet_cycles;
	dir_row_t rows[$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Threshold in units of 1e-8 floored to Q8.8, compared as "at most".
	function automatic bit at_most(input longint x, input longint t_e8);
		longint scaled;
		longint q;
		scaled = t_e8 * 256;
		if (scaled >= 0)
			q = scaled / 100000000;
		else
			q = -((-scaled + 99999999) / 100000000);
		return x <= q;
	endfunction

	// Fixed decision tree on SINR and speed plus the categorical inputs.
	function automatic int tree_choice(input longint s, input longint v, input bit c0,
			input bit c2, input bit b0, input bit a1);
		if (at_most(s, 64'd430839133)) begin
			if (at_most(s, -96642464)) begin
				if (at_most(s, -248702228)) return 3;
				if (c0 && at_most(v, 64'd7019161415)) begin
					if (a1) return 3;
					return at_most(v, 64'd1802309258) ? 4 : 3;
				end
				return 3;
			end
			if (c0) begin
				if (at_most(s, 64'd126274550)) begin
					if (b0) return at_most(v, 64'd6853525734) ? 4 : 3;
					return 3;
				end
				return 4;
			end
			if (at_most(v, 64'd55807936)) begin
				if (at_most(s, 64'd156168413)) return at_most(s, 64'd41184593) ? 4 : 3;
				return 4;
			end
			return 3;
		end
		if (at_most(s, 64'd1256060553)) begin
			if (at_most(s, 64'd617890668)) begin
				if (at_most(v, 64'd399698102)) begin
					if (c0) return at_most(v, 64'd41157654) ? 9 : 4;
					return 4;
				end
				if (at_most(s, 64'd454392958)) return c2 ? 9 : 4;
				if (at_most(v, 64'd12433786774)) return 4;
				return c2 ? 4 : 3;
			end
			if (at_most(s, 64'd882764578)) begin
				if (c0) begin
					if (at_most(s, 64'd705531454)) begin
						if (at_most(v, 64'd100115356)) return a1 ? 11 : 9;
						if (at_most(s, 64'd662034631)) return 9;
						return at_most(s, 64'd676861310) ? 11 : 9;
					end
					if (at_most(v, 64'd1273514843)) begin
						if (a1) return 11;
						return at_most(v, 64'd453145599) ? 14 : 11;
					end
					return at_most(v, 64'd11855266190) ? 11 : 9;
				end
				if (a1) begin
					if (at_most(v, 64'd150999677)) return at_most(s, 64'd724577546) ? 9 : 11;
					return 9;
				end
				if (c2) begin
					if (at_most(s, 64'd753271031)) return b0 ? 9 : 4;
					return at_most(v, 64'd7928376770) ? 9 : 4;
				end
				return at_most(v, 64'd12831045914) ? 4 : 3;
			end
			if (at_most(s, 64'd1087900114)) begin
				if (a1) return 11;
				if (c0) begin
					if (b0) return at_most(s, 64'd906382465) ? 11 : 14;
					return 11;
				end
				return at_most(v, 64'd3681468201) ? 11 : 9;
			end
			if (at_most(v, 64'd10910931778)) begin
				if (c0) return at_most(v, 64'd472279215) ? 17 : 14;
				if (a1) return 14;
				return at_most(v, 64'd3220698929) ? 11 : 9;
			end
			if (at_most(s, 64'd1145182133)) return at_most(s, 64'd1113978100) ? 11 : 9;
			return 11;
		end
		if (at_most(s, 64'd1716288471)) begin
			if (c0) begin
				if (at_most(v, 64'd11294168854)) begin
					if (at_most(s, 64'd1670649338))
						return at_most(v, 64'd10961881256) ? 17 : 11;
					return at_most(s, 64'd1677868176) ? 20 : 17;
				end
				if (b0) return 17;
				return at_most(s, 64'd1533669233) ? 11 : 14;
			end
			if (at_most(v, 64'd3318185043)) begin
				if (a1) return at_most(s, 64'd1421487474) ? 14 : 17;
				if (at_most(s, 64'd1494774055)) return at_most(v, 64'd850468922) ? 14 : 11;
				return 14;
			end
			if (a1) begin
				if (at_most(s, 64'd1459946728)) return at_most(v, 64'd11704510117) ? 14 : 11;
				return 17;
			end
			if (at_most(s, 64'd1408268023)) return at_most(s, 64'd1307105064) ? 11 : 9;
			return 11;
		end
		if (at_most(v, 64'd5835043716)) begin
			if (at_most(s, 64'd2322297764)) begin
				if (at_most(s, 64'd1882577515)) begin
					if (c0) return 20;
					if (b0) return 17;
					if (at_most(v, 64'd1129361582)) return 17;
					return a1 ? 17 : 14;
				end
				if (at_most(v, 64'd828355694)) begin
					if (at_most(s, 64'd2062684345)) return c0 ? 24 : 20;
					if (c0) return 25;
					if (a1) return b0 ? 24 : 25;
					return 20;
				end
				if (c0) begin
					if (at_most(v, 64'd3418718910)) return at_most(v, 64'd1419350100) ? 24 : 20;
					return 24;
				end
				if (a1) return 20;
				if (c2) return b0 ? 20 : 14;
				return 14;
			end
			if (at_most(v, 64'd1215252781)) begin
				if (c0) return 25;
				if (c2) begin
					if (a1) return 25;
					return at_most(s, 64'd2811477184) ? 20 : 24;
				end
				if (b0) return 24;
				return at_most(v, 64'd55706936) ? 25 : 24;
			end
			if (b0) begin
				if (at_most(s, 64'd2537801456)) begin
					if (at_most(s, 64'd2449721813)) begin
						if (at_most(s, 64'd2374157238)) return 24;
						return at_most(s, 64'd2433358669) ? 20 : 24;
					end
					return 20;
				end
				return 24;
			end
			if (at_most(v, 64'd3600370216)) begin
				if (c0) return at_most(s, 64'd2615872860) ? 24 : 20;
				return at_most(v, 64'd2845121098) ? 20 : 17;
			end
			return c2 ? 17 : 14;
		end
		if (c0) begin
			if (at_most(v, 64'd12184026337)) begin
				if (at_most(s, 64'd2434941578)) return 20;
				return a1 ? 24 : 20;
			end
			if (b0) return at_most(s, 64'd2112915993) ? 17 : 20;
			return at_most(v, 64'd13305709076) ? 17 : 14;
		end
		if (b0) begin
			if (a1) return at_most(v, 64'd12573830414) ? 17 : 14;
			return c2 ? 14 : 11;
		end
		return 11;
	endfunction

	// Nearest allowed MCS, the lower one on a tie.
	function automatic int nearest_mcs(input int raw);
		int grid[9] = '{3, 4, 9, 11, 14, 17, 20, 24, 25};
		int pick;
		int d_new, d_old;
		pick = grid[0];
		for (int i = 1; i < 9; i++) begin
			d_new = grid[i] > raw ? grid[i] - raw : raw - grid[i];
			d_old = pick > raw ? pick - raw : raw - pick;
			if (d_new < d_old) pick = grid[i];
		end
		return pick;
	endfunction

	// Advances the shadow state for one accepted transaction; returns 1 with a result.
	function automatic bit link_update(input link_item_t it, output mcs_result_t res);
		logic [33:0] acc;
		int tree_out, sum;
		res = '{default: '0};
		if (it.op == OP_FEEDBACK) begin
			acc = bler_avg * 34'(ALPHA_KEEP);
			if (!it.ack) acc = acc + (34'(ALPHA_Q16) << 16);
			bler_avg = acc[31:16];
			if (it.ack) nack_count = 0;
			else if (nack_count != 8'd255) nack_count = nack_count + 1;
			return 1'b0;
		end
		if (nack_count > NACK_LIMIT) begin
			res.mcs = MCS_MIN;
			res.tree = MCS_MIN;
			res.ofs = 3'(link_offset);
			res.fb = 1'b1;
			return 1'b1;
		end
		if (bler_avg > bler_goal) begin
			if (link_offset > -3) link_offset--;
		end else if (2 * int'(bler_avg) < int'(bler_goal)) begin
			if (link_offset < 2) link_offset++;
		end
		tree_out = tree_choice(longint'(it.sinr), longint'(it.speed), it.cls == 0, it.cls <= 2,
			it.band == 0, it.ant <= 1);
		sum = tree_out + link_offset;
		if (sum < 3) sum = 3;
		if (sum > 25) sum = 25;
		res.mcs = 5'(nearest_mcs(sum));
		res.tree = 5'(tree_out);
		res.ofs = 3'(link_offset);
		res.fb = 1'b0;
		return 1'b1;
	endfunction

	// Idle gap: mostly none or short, now and then long.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic link_item_t random_item(input int req_pct, input int ack_pct);
		link_item_t it;
		it.op = ($urandom_range(0, 99) < req_pct) ? OP_REQUEST : OP_FEEDBACK;
		it.ack = ($urandom_range(0, 99) < ack_pct);
		if ($urandom_range(0, 3) == 0)
			it.sinr = 16'($urandom);
		else
			it.sinr = 16'($urandom_range(0, 47 * 256) - 6 * 256);
		if ($urandom_range(0, 3) == 0)
			it.speed = 16'($urandom);
		else
			it.speed = 16'($urandom_range(0, 140 * 256));
		it.cls = 2'($urandom);
		it.band = 1'($urandom);
		it.ant = 4'($urandom);
		return it;
	endfunction

	function automatic dir_row_t mk_row(input logic op, input logic ack, input int sinr,
			input int speed, input int cls, input int band, input int ant);
		dir_row_t r;
		r.item = '{op, ack, 16'(sinr), 16'(speed), 2'(cls), 1'(band), 4'(ant)};
		r.typed = 1'b0;
		r.res = '{default: '0};
		return r;
	endfunction

	// Offers one transaction after a random gap and records it once accepted.
	task automatic offer(input link_item_t it, input bit typed, input mcs_result_t typed_res);
		int gap;
		mcs_result_t res;
		gap = gap_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, it.ant, it.band, it.cls, it.speed, it.sinr, it.ack, it.op};
		do @(posedge clk); while (!s_axis_tready);
		if (it.op == OP_REQUEST) n_requests++;
		else n_feedback++;
		if (link_update(it, res)) begin
			if (res.fb) n_fallback++;
			pending_mcs.push_back(typed ? typed_res : res);
		end
	endtask

	// Stops offering and waits until every result is back and the block is quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_mcs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_target(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bler_goal = value;
	endtask

	task automatic random_run(input int count, input int req_pct, input int ack_pct);
		mcs_result_t none;
		none = '{default: '0};
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			if (hold_request == 1'b0 && i == count / 2 && req_pct > 80) hold_request = 1'b1;
			offer(random_item(req_pct, ack_pct), 1'b0, none);
		end
		calm = 1'b0;
	endtask

	// Receiver: checks each result transaction and applies back-pressure.
	initial begin
		mcs_result_t want;
		m_axis_tready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (pending_mcs.size() == 0) begin
					$error("result transaction with no request waiting");
					fail_count++;
				end else begin
					want = pending_mcs.pop_front();
					if (m_axis_tdata[4:0] !== want.mcs) begin
						$error("mcs: expected %0d, got %0d", want.mcs, m_axis_tdata[4:0]);
						fail_count++;
					end
					if (m_axis_tdata[9:5] !== want.tree) begin
						$error("tree_mcs: expected %0d, got %0d", want.tree, m_axis_tdata[9:5]);
						fail_count++;
					end
					if (m_axis_tdata[12:10] !== want.ofs) begin
						$error("offset_now: expected %0d, got %0d", want.ofs,
							$signed(m_axis_tdata[12:10]));
						fail_count++;
					end
					if (m_axis_tuser !== want.fb) begin
						$error("fallback: expected %0d, got %0d", want.fb, m_axis_tuser);
						fail_count++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(5, 30);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending_mcs.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Main stimulus sequence.
	initial begin
		dir_row_t r;
		mcs_result_t none;
		none = '{default: '0};
		fail_count = 0;
		n_requests = 0;
		n_feedback = 0;
		n_fallback = 0;
		n_results = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		bler_avg = '0;
		nack_count = '0;
		link_offset = 0;
		bler_goal = 16'd6554;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed rows: extremes, tree boundaries, zero and large antenna counts.
		r = mk_row(OP_REQUEST, 1'b0, -32768, 0, 0, 0, 1);
		r.typed = 1'b1;
		r.res = '{5'd4, 5'd3, 3'sd1, 1'b0};
		rows.push_back(r);
		r = mk_row(OP_REQUEST, 1'b1, 32767, 0, 0, 0, 1);
		r.typed = 1'b1;
		r.res = '{5'd25, 5'd25, 3'sd2, 1'b0};
		rows.push_back(r);
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 32767, 65535, 3, 1, 8));
		rows.push_back(mk_row(OP_FEEDBACK, 1'b0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(OP_FEEDBACK, 1'b1, -1, 65535, 3, 1, 15));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, -248, 100, 0, 0, 0));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, -247, 100, 0, 0, 2));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 1102, 0, 1, 1, 15));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 1103, 0, 2, 0, 1));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 3215, 30000, 0, 0, 4));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 3216, 65535, 0, 1, 0));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 4393, 1000, 3, 0, 1));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 4394, 14937, 1, 1, 2));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 4394, 14938, 3, 1, 8));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, 0, 0, 0, 0, 1));
		rows.push_back(mk_row(OP_FEEDBACK, 1'b0, 5000, 5000, 2, 1, 3));
		rows.push_back(mk_row(OP_REQUEST, 1'b1, 6000, 2000, 2, 1, 7));
		rows.push_back(mk_row(OP_REQUEST, 1'b0, -1, 32768, 3, 1, 15));
		foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].res);
		drain();

		// Target of zero: any nonzero average pulls the offset down.
		write_target(16'd0);
		random_run(90, 60, 50);
		drain();

		// Largest target: the offset climbs to its cap.
		write_target(16'hFFFF);
		random_run(90, 60, 50);
		drain();

		// Random target with long NACK runs to reach the fallback answer.
		write_target(16'($urandom));
		for (int i = 0; i < 104; i++)
			offer('{OP_FEEDBACK, 1'b0, 16'($urandom), 16'($urandom), 2'($urandom),
				1'($urandom), 4'($urandom)}, 1'b0, none);
		random_run(20, 100, 0);
		offer('{OP_FEEDBACK, 1'b1, 16'd0, 16'd0, 2'd0, 1'b0, 4'd1}, 1'b0, none);
		random_run(80, 60, 75);
		drain();

		// Moderate target with a long receiver hold-off mid phase.
		write_target(16'd3000);
		random_run(90, 90, 95);
		drain();

		write_target(16'd6554);
		random_run(60, 60, 90);
		drain();

		$display("covered %0d requests (%0d fallback) and %0d feedback items, %0d results",
			n_requests, n_fallback, n_feedback, n_results);
		$display("targets swept from 0 to 65535 with receiver stalls and sender gaps");
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
